/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sorted pair table checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define SPT_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted pair table: assertion failed");

// Next-cycle implication, off while reset is asserted
`define SPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted pair table: assertion failed");

// Next-cycle implication that also holds across reset
`define SPT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sorted pair table: assertion failed");

`endif

/* src/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// Types, widths and codes shared by the sorted pair table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int KEY_W       = 64;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;
    localparam int MATCH_W     = 7;
    localparam int ENTRY_W     = 2 * KEY_W;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_EXISTS,
        CMD_INSERT,
        CMD_DELETE,
        CMD_LIST
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK,
        STAT_NOT_FOUND,
        STAT_DUP,
        STAT_FULL
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS,
        ST_PUT,
        ST_DEL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] user_key;
        logic [KEY_W-1:0] device_key;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [KEY_W-1:0]   listed_device;
        logic               has_entry;
        logic [MATCH_W-1:0] match_count;
        logic               final_result;
    } t_result;

endpackage

`default_nettype wire

/* src/spt_ram.sv */
// ----------------------------------------------------------------------------
// spt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/sorted_pair_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_pair_table_top
// Table of (user key, device key) pairs kept sorted by unsigned user key,
// with exists, insert, delete and list commands.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one command word: tuser carries the command,
//   tdata the user key and device key. The master channel returns result
//   words; tlast marks the last result of a command. Exists, insert and
//   delete give one result each, list gives one per matching entry (or one
//   empty result when nothing matches).
//   One command at a time. An exists command scans the stored entries up
//   to an exact hit, a list command scans them all, delete scans to the
//   hit and then moves each following entry down, and insert scans for a
//   match and then shifts the larger entries up. The slave side reopens as
//   the last result word is loaded. The single read port of the pair store
//   reads one entry per cycle while the scan is not paused.
//   Results leave through an output register, so the next command is taken
//   while the last result still waits. A stalled receiver holds the result
//   word and, during a list, pauses the scan once one more match is pending.
//   Reset empties the table and drops any pending result; the store itself
//   is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_pair_table_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Command channel
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [63:0] user_key, [127:64] device_key
    input  wire logic [spt_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [1:0] command
    input  wire logic [spt_pkg::CMD_W-1:0]          i_s_axis_tuser,
    // Result channel
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [63:0] listed_device, [70:64] match_count, [71] zero
    output logic      [spt_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // [1:0] status, [2] has_entry
    output logic      [spt_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,
    // final_result
    output logic                                    o_m_axis_tlast
);

    localparam int IDX_W   = spt_pkg::IDX_W;
    localparam int CNT_W   = spt_pkg::CNT_W;
    localparam int KEY_W   = spt_pkg::KEY_W;
    localparam int MATCH_W = spt_pkg::MATCH_W;
    localparam int PAD_W   = spt_pkg::OUT_TDATA_W - MATCH_W - KEY_W;

    // Control state
    spt_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_chk_vld, n_chk_vld;
    logic             r_pend_vld, n_pend_vld;
    logic             r_out_vld, n_out_vld;

    // Payload
    spt_pkg::t_cmd    r_cmd, n_cmd;
    spt_pkg::t_status r_status, n_status;
    logic [KEY_W-1:0] r_user, n_user;
    logic [KEY_W-1:0] r_dev, n_dev;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_chk_addr, n_chk_addr;
    logic [IDX_W-1:0] r_put, n_put;
    logic [KEY_W-1:0] r_pend_dev, n_pend_dev;
    logic [CNT_W-1:0] r_match_n, n_match_n;
    spt_pkg::t_result r_out, n_out;

    // Store ports
    logic                      w_rd_en;
    logic [IDX_W-1:0]          w_rd_addr;
    logic [spt_pkg::ENTRY_W-1:0] w_rd_data;
    logic                      w_wr_en;
    logic [IDX_W-1:0]          w_wr_addr;
    spt_pkg::t_entry           w_wr_data;
    spt_pkg::t_entry           w_rd;

    // Shared decisions
    logic w_out_free;
    logic w_user_hit;
    logic w_exact_hit;
    logic w_idx_more;
    logic w_scan_end;
    logic w_is_list;
    logic w_list_stall;
    logic w_full;
    logic w_ins_stop;
    logic w_ins_end;

    spt_ram #(
        .DEPTH  (spt_pkg::TABLE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (spt_pkg::ENTRY_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // Compare the entry read from the store against the command keys
    assign w_rd         = spt_pkg::t_entry'(w_rd_data);
    assign w_out_free   = !r_out_vld || i_m_axis_tready;
    assign w_user_hit   = r_chk_vld && (w_rd.user_key == r_user);
    assign w_exact_hit  = w_user_hit && (w_rd.device_key == r_dev);
    assign w_idx_more   = r_idx < r_count;
    assign w_scan_end   = !r_chk_vld && !w_idx_more;
    assign w_is_list    = r_cmd == spt_pkg::CMD_LIST;
    assign w_list_stall = w_is_list && w_user_hit && r_pend_vld && !w_out_free;
    assign w_full       = r_count == CNT_W'(spt_pkg::TABLE_DEPTH);
    assign w_ins_stop   = r_chk_vld && !(w_rd.user_key > r_user);
    assign w_ins_end    = w_ins_stop || (!r_chk_vld && (r_idx == '0));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spt_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = spt_pkg::ST_SCAN;
                end
            end
            spt_pkg::ST_SCAN: begin
                if (w_is_list) begin
                    if (w_scan_end) begin
                        n_state = spt_pkg::ST_EMIT;
                    end
                end else if (w_exact_hit) begin
                    if (r_cmd == spt_pkg::CMD_DELETE) begin
                        n_state = spt_pkg::ST_DEL;
                    end else begin
                        n_state = spt_pkg::ST_EMIT;
                    end
                end else if (w_scan_end) begin
                    if ((r_cmd == spt_pkg::CMD_INSERT) && !w_full) begin
                        n_state = spt_pkg::ST_INS;
                    end else begin
                        n_state = spt_pkg::ST_EMIT;
                    end
                end
            end
            spt_pkg::ST_INS: begin
                if (w_ins_end) begin
                    n_state = spt_pkg::ST_PUT;
                end
            end
            spt_pkg::ST_PUT: begin
                n_state = spt_pkg::ST_EMIT;
            end
            spt_pkg::ST_DEL: begin
                if (w_scan_end) begin
                    n_state = spt_pkg::ST_EMIT;
                end
            end
            spt_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = spt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spt_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_count    = r_count;
        n_chk_vld  = r_chk_vld;
        n_pend_vld = r_pend_vld;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        n_cmd      = r_cmd;
        n_status   = r_status;
        n_user     = r_user;
        n_dev      = r_dev;
        n_idx      = r_idx;
        n_chk_addr = r_chk_addr;
        n_put      = r_put;
        n_pend_dev = r_pend_dev;
        n_match_n  = r_match_n;
        n_out      = r_out;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_idx[IDX_W-1:0];
        w_wr_en    = 1'b0;
        w_wr_addr  = r_put;
        w_wr_data  = '{user_key: r_user, device_key: r_dev};

        case (r_state)
            spt_pkg::ST_IDLE: begin
                // Capture the command word
                if (i_s_axis_tvalid) begin
                    n_cmd      = spt_pkg::t_cmd'(i_s_axis_tuser);
                    n_user     = i_s_axis_tdata[KEY_W-1:0];
                    n_dev      = i_s_axis_tdata[2*KEY_W-1:KEY_W];
                    n_idx      = '0;
                    n_chk_vld  = 1'b0;
                    n_pend_vld = 1'b0;
                    n_match_n  = '0;
                    n_status   = spt_pkg::STAT_OK;
                end
            end
            spt_pkg::ST_SCAN: begin
                if (!w_list_stall) begin
                    // Advance the read pointer one entry per cycle
                    w_rd_en    = w_idx_more;
                    n_chk_vld  = w_idx_more;
                    n_chk_addr = r_idx[IDX_W-1:0];
                    if (w_idx_more) begin
                        n_idx = r_idx + 1'b1;
                    end
                    if (w_is_list) begin
                        // Push the previous match out, hold the new one
                        if (w_user_hit) begin
                            if (r_pend_vld) begin
                                n_out_vld = 1'b1;
                                n_out     = '{status:        spt_pkg::STAT_OK,
                                              listed_device: r_pend_dev,
                                              has_entry:     1'b1,
                                              match_count:   MATCH_W'(r_match_n),
                                              final_result:  1'b0};
                            end
                            n_pend_vld = 1'b1;
                            n_pend_dev = w_rd.device_key;
                            n_match_n  = r_match_n + 1'b1;
                        end
                    end else if (w_exact_hit) begin
                        w_rd_en   = 1'b0;
                        n_chk_vld = 1'b0;
                        case (r_cmd)
                            spt_pkg::CMD_INSERT: begin
                                n_status = spt_pkg::STAT_DUP;
                            end
                            spt_pkg::CMD_DELETE: begin
                                // Close the gap starting above the hit
                                n_status = spt_pkg::STAT_OK;
                                n_idx    = CNT_W'(r_chk_addr) + 1'b1;
                            end
                            default: begin
                                n_status = spt_pkg::STAT_OK;
                            end
                        endcase
                    end else if (w_scan_end) begin
                        if (r_cmd == spt_pkg::CMD_INSERT) begin
                            if (w_full) begin
                                n_status = spt_pkg::STAT_FULL;
                            end else begin
                                n_status  = spt_pkg::STAT_OK;
                                n_idx     = r_count;
                                n_chk_vld = 1'b0;
                            end
                        end else begin
                            n_status = spt_pkg::STAT_NOT_FOUND;
                        end
                    end
                end
            end
            spt_pkg::ST_INS: begin
                // Move larger entries up one place, walking down from the top
                if (r_chk_vld && !w_ins_stop) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_chk_addr + 1'b1;
                    w_wr_data = w_rd;
                end
                if (w_ins_stop) begin
                    n_put = r_chk_addr + 1'b1;
                end else if (!r_chk_vld && (r_idx == '0)) begin
                    n_put = '0;
                end
                if (!w_ins_end && (r_idx != '0)) begin
                    w_rd_en    = 1'b1;
                    w_rd_addr  = IDX_W'(r_idx - 1'b1);
                    n_idx      = r_idx - 1'b1;
                    n_chk_addr = IDX_W'(r_idx - 1'b1);
                    n_chk_vld  = 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                end
            end
            spt_pkg::ST_PUT: begin
                // Drop the new pair into the opened slot
                w_wr_en  = 1'b1;
                n_count  = r_count + 1'b1;
                n_status = spt_pkg::STAT_OK;
            end
            spt_pkg::ST_DEL: begin
                // Move each following entry down one place
                if (r_chk_vld) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_chk_addr - 1'b1;
                    w_wr_data = w_rd;
                end
                w_rd_en    = w_idx_more;
                n_chk_vld  = w_idx_more;
                n_chk_addr = r_idx[IDX_W-1:0];
                if (w_idx_more) begin
                    n_idx = r_idx + 1'b1;
                end
                if (w_scan_end) begin
                    n_count = r_count - 1'b1;
                end
            end
            spt_pkg::ST_EMIT: begin
                // Last word of the command; carries a held list match if any
                if (w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out      = '{status:        r_status,
                                   listed_device: r_pend_vld ? r_pend_dev : {KEY_W{1'b0}},
                                   has_entry:     r_pend_vld,
                                   match_count:   r_pend_vld ? MATCH_W'(r_match_n)
                                                             : {MATCH_W{1'b0}},
                                   final_result:  1'b1};
                    n_pend_vld = 1'b0;
                end
            end
            default: begin
                n_chk_vld = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spt_pkg::ST_IDLE;
            r_count    <= '0;
            r_chk_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_chk_vld  <= n_chk_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_status   <= n_status;
        r_user     <= n_user;
        r_dev      <= n_dev;
        r_idx      <= n_idx;
        r_chk_addr <= n_chk_addr;
        r_put      <= n_put;
        r_pend_dev <= n_pend_dev;
        r_match_n  <= n_match_n;
        r_out      <= n_out;
    end

    // Ports
    assign o_s_axis_tready = r_state == spt_pkg::ST_IDLE;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out.match_count, r_out.listed_device};
    assign o_m_axis_tuser  = {r_out.has_entry, r_out.status};
    assign o_m_axis_tlast  = r_out.final_result;

endmodule

`default_nettype wire

/* src/spt_checker.sv */
// ----------------------------------------------------------------------------
// spt_checker
// Port-level checks on the sorted pair table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spt_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic [spt_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input wire logic [spt_pkg::CMD_W-1:0]       i_s_axis_tuser,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [spt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [spt_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser,
    input wire logic                            o_m_axis_tlast
);

    logic w_cmd_seen;

    // Observe the command fields so the binding covers every port
    assign w_cmd_seen = (^i_s_axis_tdata) | (^i_s_axis_tuser);

    // Reset drops any pending result word
    `SPT_ASSERT_NEXT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n, !o_m_axis_tvalid)

    // One command at a time: the slave side closes right after a command word
    `SPT_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && (w_cmd_seen || !w_cmd_seen), !o_s_axis_tready)

    // Only list matches come without tlast, and they carry an entry
    `SPT_ASSERT(a_mid_word_entry, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, o_m_axis_tuser[2] && (o_m_axis_tuser[1:0] == spt_pkg::STAT_OK))

    // A word without an entry has device key and count at zero
    `SPT_ASSERT(a_empty_word_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[2], o_m_axis_tdata == '0)

    // A stalled result word holds its data and tlast
    `SPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

endmodule

bind sorted_pair_table_top spt_checker u_spt_checker (.*);

`default_nettype wire
